// ===== hw/rtl/jet_pkg.sv =====
// jet_pkg: types, codes and helpers shared by the joystick event translator.
// Holds the input/output word structs, queue bundle and config structs.
// No dependencies.
package jet_pkg;

  // Input action codes; codes above ACT_LOAD_AXIS are ignored.
  typedef enum logic [2:0] {
    ACT_BUTTON      = 3'd0,
    ACT_AXIS        = 3'd1,
    ACT_HAT         = 3'd2,
    ACT_LOAD_BUTTON = 3'd3,
    ACT_LOAD_AXIS   = 3'd4
  } jet_action_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BUTTON_COUNT   = 3'd0,
    REG_AXIS_COUNT     = 3'd1,
    REG_HAT_COUNT      = 3'd2,
    REG_AXIS_THRESHOLD = 3'd3,
    REG_HAT_LEFT_ID    = 3'd4,
    REG_HAT_RIGHT_ID   = 3'd5,
    REG_HAT_UP_ID      = 3'd6,
    REG_HAT_DOWN_ID    = 3'd7
  } jet_reg_e;

  // Direction of one hat axis.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } jet_dir_e;

  localparam logic [3:0]  HAT_UP    = 4'd1;
  localparam logic [3:0]  HAT_RIGHT = 4'd2;
  localparam logic [3:0]  HAT_DOWN  = 4'd4;
  localparam logic [3:0]  HAT_LEFT  = 4'd8;

  localparam logic [14:0] AXIS_THRESHOLD_RESET = 15'd16384;

  localparam int QDEPTH = 2;   // event queue depth, power of two
  localparam int EVMAX  = 4;   // most events one item can cause

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         index;
    logic signed [15:0] value;
    logic [15:0]        map_low;
    logic [15:0]        map_high;
  } jet_in_t;

  typedef struct packed {
    logic [15:0] button_id;
    logic        pressed;
    logic        last;
  } jet_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic        pressed;
  } jet_event_t;

  // All events of one item; last_sel is the slot of the final event.
  typedef struct packed {
    jet_event_t [EVMAX-1:0] events;
    logic [1:0]             last_sel;
  } jet_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jet_qsts_t;

  typedef struct packed {
    logic [8:0]  button_count;
    logic [8:0]  axis_count;
    logic [4:0]  hat_count;
    logic [14:0] axis_threshold;
    logic [15:0] hat_left_id;
    logic [15:0] hat_right_id;
    logic [15:0] hat_up_id;
    logic [15:0] hat_down_id;
  } jet_cfg_t;

  function automatic jet_dir_e hat_dir(logic [3:0] bits, logic [3:0] neg, logic [3:0] pos);
    logic [3:0] m;
    m = bits & (neg | pos);
    if (m == neg) return DIR_NEG;
    if (m == pos) return DIR_POS;
    return DIR_NONE;
  endfunction

endpackage

// ===== hw/rtl/joystick_event_translator.sv =====
// joystick_event_translator: top level; holds the configuration registers
// and joins front, event queue and back. Depends on jet_pkg and all jet_* modules.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one raw gamepad
//   word per accept: button, axis, hat, or a button/axis map load.
//   Output channel (out_valid_o / out_stall_i / out_word_o) gives the press and
//   release words; last marks the final word caused by one input word.
//   Config port writes one register per cycle when cfg_we_i is high; write it
//   only while the block is idle.
// Path: the front stage register, the event queue, then the output register.
// Throughput: one input word per cycle while words cause at most one event
//   and the receiver does not stall; a word causing N events (up to 4) gives
//   N output words in turn from the single output register draining the queue.
// Per-index state lives in registered-read RAMs; the lookup is issued at
//   accept, so each input word waits in the front stage for its read data.
// Reset: counts clear (every index ignored), threshold returns to 16384, hat
//   ids clear. Then a clearing pass zeroes all held/previous/map RAMs, one
//   entry per cycle, covering the largest of the three sizes (256 entries with
//   default sizes), with in_stall_o high throughout.
// Receiver stall: the output word holds; the two-deep event queue fills, then
//   the front stage holds any word that causes events and in_stall_o rises.
module joystick_event_translator #(
  parameter int MAX_BUTTONS = 256,
  parameter int MAX_AXES    = 256,
  parameter int MAX_HATS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jet_pkg::jet_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jet_pkg::jet_out_t out_word_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import jet_pkg::*;

  jet_cfg_t    cfg_q;
  jet_bundle_t push_bundle, head_bundle;
  jet_qsts_t   qsts;
  logic        q_push, q_pop;
  logic        init_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{button_count: '0, axis_count: '0, hat_count: '0,
                 axis_threshold: AXIS_THRESHOLD_RESET,
                 hat_left_id: '0, hat_right_id: '0, hat_up_id: '0, hat_down_id: '0};
    end else if (cfg_we_i) begin
      unique case (jet_reg_e'(cfg_index_i))
        REG_BUTTON_COUNT:   cfg_q.button_count   <= cfg_data_i[8:0];
        REG_AXIS_COUNT:     cfg_q.axis_count     <= cfg_data_i[8:0];
        REG_HAT_COUNT:      cfg_q.hat_count      <= cfg_data_i[4:0];
        REG_AXIS_THRESHOLD: cfg_q.axis_threshold <= cfg_data_i[14:0];
        REG_HAT_LEFT_ID:    cfg_q.hat_left_id    <= cfg_data_i;
        REG_HAT_RIGHT_ID:   cfg_q.hat_right_id   <= cfg_data_i;
        REG_HAT_UP_ID:      cfg_q.hat_up_id      <= cfg_data_i;
        REG_HAT_DOWN_ID:    cfg_q.hat_down_id    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept, state lookup, classify, build bundle
  jet_front #(
    .MAX_BUTTONS(MAX_BUTTONS),
    .MAX_AXES   (MAX_AXES),
    .MAX_HATS   (MAX_HATS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .in_word_i,
    .push_o    (q_push),
    .bundle_o  (push_bundle),
    .qsts_i    (qsts),
    .init_busy_o (init_busy)
  );

  // event queue decouples lookup from output
  jet_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i   (q_push),
    .bundle_i (push_bundle),
    .pop_i    (q_pop),
    .bundle_o (head_bundle),
    .qsts_o   (qsts)
  );

  // back: serialize events onto the output
  jet_back u_back (
    .clk_i,
    .rst_ni,
    .qsts_i   (qsts),
    .bundle_i (head_bundle),
    .pop_o    (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_word_o
  );

  // front only holds its word when the queue has no room or RAMs are clearing
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (qsts.full || init_busy))
    else $error("input stalled while event queue has room");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !qsts.full)
    else $error("bundle pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !qsts.empty)
    else $error("bundle popped from an empty queue");

  a_qsts_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qsts.full && qsts.empty))
    else $error("queue reports full and empty together");

endmodule

// ===== hw/rtl/jet_ram.sv =====
// jet_ram: generic single-write, single-read RAM with registered read.
// Write-first on a same-address collision. No dependencies.
module jet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/jet_fifo.sv =====
// jet_fifo: short queue of event bundles between front and back.
// Depends on jet_pkg.
module jet_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jet_pkg::jet_bundle_t bundle_i,
  input  logic                pop_i,
  output jet_pkg::jet_bundle_t bundle_o,
  output jet_pkg::jet_qsts_t  qsts_o
);
  import jet_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  jet_bundle_t     entry_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= bundle_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  assign bundle_o     = entry_q[rd_ptr_q];
  assign qsts_o.full  = (cnt_q == (PW+1)'(QDEPTH));
  assign qsts_o.empty = (cnt_q == '0);

endmodule

// ===== hw/rtl/jet_front.sv =====
// jet_front: accepts input words, looks up per-index state, classifies the
// item and builds its event bundle. Depends on jet_pkg and jet_ram.
module jet_front #(
  parameter int MAX_BUTTONS = 256,
  parameter int MAX_AXES    = 256,
  parameter int MAX_HATS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jet_pkg::jet_cfg_t    cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  jet_pkg::jet_in_t     in_word_i,
  output logic                 push_o,
  output jet_pkg::jet_bundle_t bundle_o,
  input  jet_pkg::jet_qsts_t   qsts_i,
  output logic                 init_busy_o
);
  import jet_pkg::*;

  localparam int BAW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int AAW = (MAX_AXES > 1)    ? $clog2(MAX_AXES)    : 1;
  localparam int HAW = (MAX_HATS > 1)    ? $clog2(MAX_HATS)    : 1;

  // clearing pass covers the largest of the three stores
  localparam int CLR_LEN = (MAX_BUTTONS > MAX_AXES) ?
                           ((MAX_BUTTONS > MAX_HATS) ? MAX_BUTTONS : MAX_HATS) :
                           ((MAX_AXES > MAX_HATS) ? MAX_AXES : MAX_HATS);

  // stage register: the item whose lookups are in flight
  logic     b_valid_q;
  jet_in_t  b_word_q;

  // clearing pass after reset zeroes every store entry
  logic       clr_busy_q;
  logic [8:0] clr_cnt_q;
  logic       clr_b, clr_a, clr_h;

  logic accept, advance;

  logic [BAW-1:0] b_baddr, bw_addr;
  logic [AAW-1:0] b_aaddr, aw_addr;
  logic [HAW-1:0] b_haddr, hw_addr;
  logic [8:0]     idx9;
  logic           btn_ok, axis_ok, hat_ok;

  logic        held_rd;
  logic [15:0] bmap_rd, apre_rd;
  logic [31:0] amap_rd;
  logic [3:0]  hat_rd;

  logic [15:0] bmap_v, alow_v, ahigh_v;
  logic [3:0]  ob;
  logic        st, held;

  logic signed [16:0] v_s, p_s, thr_pos, thr_neg;
  logic               lo_n, hi_n, lo_p, hi_p;
  jet_dir_e           nx, ox, ny, oy;

  logic                   held_we, bmap_we, amap_we, apre_we, hat_we;
  jet_event_t [EVMAX-1:0] ev;
  logic [2:0]             n;

  assign accept  = in_valid_i && !in_stall_o;
  assign advance = b_valid_q && ((n == 3'd0) || !qsts_i.full);
  assign in_stall_o = clr_busy_q || (b_valid_q && !advance);
  assign push_o  = advance && (n != 3'd0);
  assign init_busy_o = clr_busy_q;

  assign b_baddr = b_word_q.index[BAW-1:0];
  assign b_aaddr = b_word_q.index[AAW-1:0];
  assign b_haddr = b_word_q.index[HAW-1:0];

  assign clr_b   = clr_busy_q && (clr_cnt_q < 9'(MAX_BUTTONS));
  assign clr_a   = clr_busy_q && (clr_cnt_q < 9'(MAX_AXES));
  assign clr_h   = clr_busy_q && (clr_cnt_q < 9'(MAX_HATS));
  assign bw_addr = clr_busy_q ? clr_cnt_q[BAW-1:0] : b_baddr;
  assign aw_addr = clr_busy_q ? clr_cnt_q[AAW-1:0] : b_aaddr;
  assign hw_addr = clr_busy_q ? clr_cnt_q[HAW-1:0] : b_haddr;

  assign idx9    = {1'b0, b_word_q.index};
  assign btn_ok  = (idx9 < cfg_i.button_count) && (idx9 < 9'(MAX_BUTTONS));
  assign axis_ok = (idx9 < cfg_i.axis_count)   && (idx9 < 9'(MAX_AXES));
  assign hat_ok  = (idx9 < {4'd0, cfg_i.hat_count}) && (idx9 < 9'(MAX_HATS));

  jet_ram #(.WIDTH(1), .DEPTH(MAX_BUTTONS)) u_held (
    .clk_i, .we_i(clr_b || (advance && held_we)), .waddr_i(bw_addr),
    .wdata_i(clr_busy_q ? 1'b0 : st),
    .re_i(accept), .raddr_i(in_word_i.index[BAW-1:0]), .rdata_o(held_rd)
  );

  jet_ram #(.WIDTH(16), .DEPTH(MAX_BUTTONS)) u_bmap (
    .clk_i, .we_i(clr_b || (advance && bmap_we)), .waddr_i(bw_addr),
    .wdata_i(clr_busy_q ? 16'd0 : b_word_q.map_low),
    .re_i(accept), .raddr_i(in_word_i.index[BAW-1:0]), .rdata_o(bmap_rd)
  );

  jet_ram #(.WIDTH(32), .DEPTH(MAX_AXES)) u_amap (
    .clk_i, .we_i(clr_a || (advance && amap_we)), .waddr_i(aw_addr),
    .wdata_i(clr_busy_q ? 32'd0 : {b_word_q.map_high, b_word_q.map_low}),
    .re_i(accept), .raddr_i(in_word_i.index[AAW-1:0]), .rdata_o(amap_rd)
  );

  jet_ram #(.WIDTH(16), .DEPTH(MAX_AXES)) u_apre (
    .clk_i, .we_i(clr_a || (advance && apre_we)), .waddr_i(aw_addr),
    .wdata_i(clr_busy_q ? 16'd0 : b_word_q.value),
    .re_i(accept), .raddr_i(in_word_i.index[AAW-1:0]), .rdata_o(apre_rd)
  );

  jet_ram #(.WIDTH(4), .DEPTH(MAX_HATS)) u_hat (
    .clk_i, .we_i(clr_h || (advance && hat_we)), .waddr_i(hw_addr),
    .wdata_i(clr_busy_q ? 4'd0 : b_word_q.value[3:0]),
    .re_i(accept), .raddr_i(in_word_i.index[HAW-1:0]), .rdata_o(hat_rd)
  );

  assign bmap_v  = bmap_rd;
  assign alow_v  = amap_rd[15:0];
  assign ahigh_v = amap_rd[31:16];
  assign ob      = hat_rd;
  assign held    = held_rd;
  assign st      = (b_word_q.value != 16'sd0);

  // axis compares on 17 bits so the negated threshold always fits
  assign v_s     = {b_word_q.value[15], b_word_q.value};
  assign p_s     = {apre_rd[15], apre_rd};
  assign thr_pos = {2'b00, cfg_i.axis_threshold};
  assign thr_neg = -thr_pos;
  assign lo_n    = (v_s <= thr_neg);
  assign hi_n    = (v_s >= thr_pos);
  assign lo_p    = (p_s <= thr_neg);
  assign hi_p    = (p_s >= thr_pos);

  assign nx = hat_dir(b_word_q.value[3:0], HAT_LEFT, HAT_RIGHT);
  assign ny = hat_dir(b_word_q.value[3:0], HAT_UP, HAT_DOWN);
  assign ox = hat_dir(ob, HAT_LEFT, HAT_RIGHT);
  assign oy = hat_dir(ob, HAT_UP, HAT_DOWN);

  // classify and collect events in order
  always_comb begin
    ev      = '0;
    n       = 3'd0;
    held_we = 1'b0;
    bmap_we = 1'b0;
    amap_we = 1'b0;
    apre_we = 1'b0;
    hat_we  = 1'b0;
    if (b_valid_q) begin
      unique case (b_word_q.action)
        ACT_BUTTON: begin
          if (btn_ok && (held != st)) begin
            held_we = 1'b1;
            if (bmap_v != 16'd0) begin
              ev[0] = '{id: bmap_v, pressed: st};
              n     = 3'd1;
            end
          end
        end
        ACT_AXIS: begin
          if (axis_ok) begin
            apre_we = 1'b1;
            if (lo_n && !lo_p) begin
              ev[0] = '{id: alow_v, pressed: 1'b1};
              n     = 3'd1;
              if (hi_p) begin
                ev[1] = '{id: ahigh_v, pressed: 1'b0};
                n     = 3'd2;
              end
            end else if (hi_n && !hi_p) begin
              if (lo_p) begin
                ev[0] = '{id: alow_v, pressed: 1'b0};
                n     = 3'd1;
              end
              ev[n[1:0]] = '{id: ahigh_v, pressed: 1'b1};
              n          = n + 3'd1;
            end else if (!lo_n && !hi_n) begin
              if (lo_p) begin
                ev[0] = '{id: alow_v, pressed: 1'b0};
                n     = 3'd1;
              end else if (hi_p) begin
                ev[0] = '{id: ahigh_v, pressed: 1'b0};
                n     = 3'd1;
              end
            end
          end
        end
        ACT_HAT: begin
          if (hat_ok) begin
            hat_we = 1'b1;
            if (nx != ox) begin
              if (ox == DIR_NEG) begin
                ev[n[1:0]] = '{id: cfg_i.hat_left_id, pressed: 1'b0};
                n          = n + 3'd1;
              end else if (ox == DIR_POS) begin
                ev[n[1:0]] = '{id: cfg_i.hat_right_id, pressed: 1'b0};
                n          = n + 3'd1;
              end
              if (nx == DIR_NEG) begin
                ev[n[1:0]] = '{id: cfg_i.hat_left_id, pressed: 1'b1};
                n          = n + 3'd1;
              end else if (nx == DIR_POS) begin
                ev[n[1:0]] = '{id: cfg_i.hat_right_id, pressed: 1'b1};
                n          = n + 3'd1;
              end
            end
            if (ny != oy) begin
              if (oy == DIR_NEG) begin
                ev[n[1:0]] = '{id: cfg_i.hat_up_id, pressed: 1'b0};
                n          = n + 3'd1;
              end else if (oy == DIR_POS) begin
                ev[n[1:0]] = '{id: cfg_i.hat_down_id, pressed: 1'b0};
                n          = n + 3'd1;
              end
              if (ny == DIR_NEG) begin
                ev[n[1:0]] = '{id: cfg_i.hat_up_id, pressed: 1'b1};
                n          = n + 3'd1;
              end else if (ny == DIR_POS) begin
                ev[n[1:0]] = '{id: cfg_i.hat_down_id, pressed: 1'b1};
                n          = n + 3'd1;
              end
            end
          end
        end
        ACT_LOAD_BUTTON: bmap_we = btn_ok;
        ACT_LOAD_AXIS:   amap_we = axis_ok;
        default: ;
      endcase
    end
  end

  assign bundle_o.events   = ev;
  assign bundle_o.last_sel = 2'(n - 3'd1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (advance) begin
        b_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 9'd1;
        if (clr_cnt_q == 9'(CLR_LEN - 1)) clr_busy_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/jet_back.sv =====
// jet_back: drains event bundles from the queue, one output word per cycle while
// the receiver does not stall, flagging the final event of each item. Depends on jet_pkg.
module jet_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jet_pkg::jet_qsts_t   qsts_i,
  input  jet_pkg::jet_bundle_t bundle_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output jet_pkg::jet_out_t    out_word_o
);
  import jet_pkg::*;

  logic       out_valid_q;
  jet_out_t   out_word_q;
  logic [1:0] sel_q;
  logic       load, is_last;
  jet_event_t cur;

  assign load    = !qsts_i.empty && (!out_valid_q || !out_stall_i);
  assign is_last = (sel_q == bundle_i.last_sel);
  assign cur     = bundle_i.events[sel_q];
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= '{button_id: cur.id, pressed: cur.pressed, last: is_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sel_q       <= is_last ? 2'd0 : sel_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== tb/sv/joystick_event_translator_test.sv =====
// Self-checking testbench for joystick_event_translator: a scoreboard class
// predicts the press/release words of each accepted gamepad word and checks the
// output channel. Depends on jet_pkg and the joystick_event_translator RTL.
module joystick_event_translator_test;
  import jet_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int BUTTON_SLOTS = 256;   // block built with default sizes
  localparam int AXIS_SLOTS   = 256;
  localparam int HAT_SLOTS    = 16;
  localparam int SETTLE_CYCLES = 12;   // front stage + two-deep queue + output reg
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int LIMIT_CYCLES = 400000;

  // Action codes the block must ignore.
  localparam logic [2:0] ACT_RSVD_A = 3'd5;
  localparam logic [2:0] ACT_RSVD_C = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  jet_in_t     in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  jet_out_t    out_word_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  joystick_event_translator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Event scoreboard: mirrors the block's registers and per-index state,
  // turns every accepted gamepad word into the press/release words it causes
  // and matches the output stream against them in order.
  class jet_event_scoreboard;
    jet_out_t          event_q[$];
    int                errors;
    int                words_in;
    int                words_out;

    logic [8:0]        button_count;
    logic [8:0]        axis_count;
    logic [4:0]        hat_count;
    logic [14:0]       threshold;
    logic [15:0]       hat_left, hat_right, hat_up, hat_down;

    bit                held [BUTTON_SLOTS];
    logic signed [15:0] axis_last [AXIS_SLOTS];
    logic [3:0]        hat_last [HAT_SLOTS];
    logic [15:0]       button_id_map [BUTTON_SLOTS];
    logic [15:0]       axis_neg_id [AXIS_SLOTS];
    logic [15:0]       axis_pos_id [AXIS_SLOTS];

    function new();
      button_count = '0;
      axis_count   = '0;
      hat_count    = '0;
      threshold    = AXIS_THRESHOLD_RESET;
      hat_left     = '0;
      hat_right    = '0;
      hat_up       = '0;
      hat_down     = '0;
      foreach (held[k]) begin
        held[k]          = 1'b0;
        button_id_map[k] = '0;
      end
      foreach (axis_last[k]) begin
        axis_last[k]   = '0;
        axis_neg_id[k] = '0;
        axis_pos_id[k] = '0;
      end
      foreach (hat_last[k]) hat_last[k] = '0;
      errors    = 0;
      words_in  = 0;
      words_out = 0;
    endfunction

    function void write_reg(jet_reg_e r, logic [15:0] d);
      case (r)
        REG_BUTTON_COUNT:   button_count = d[8:0];
        REG_AXIS_COUNT:     axis_count   = d[8:0];
        REG_HAT_COUNT:      hat_count    = d[4:0];
        REG_AXIS_THRESHOLD: threshold    = d[14:0];
        REG_HAT_LEFT_ID:    hat_left     = d;
        REG_HAT_RIGHT_ID:   hat_right    = d;
        REG_HAT_UP_ID:      hat_up       = d;
        REG_HAT_DOWN_ID:    hat_down     = d;
        default: ;
      endcase
    endfunction

    function int pending();
      return event_q.size();
    endfunction

    function void add(logic [15:0] id, logic on);
      jet_out_t e;
      e.button_id = id;
      e.pressed   = on;
      e.last      = 1'b0;
      event_q.push_back(e);
    endfunction

    // One hat axis: pushed one way only when exactly one of its two bits is set.
    function jet_dir_e hat_way(logic [3:0] bits, logic [3:0] neg, logic [3:0] pos);
      logic has_neg, has_pos;
      has_neg = |(bits & neg);
      has_pos = |(bits & pos);
      if (has_neg && !has_pos) return DIR_NEG;
      if (has_pos && !has_neg) return DIR_POS;
      return DIR_NONE;
    endfunction

    function void note_word(jet_in_t w);
      int        t, v, p, before_n;
      logic      on;
      logic [7:0] i;
      logic [3:0] nb, ob;
      jet_dir_e  nx, ox, ny, oy;
      jet_out_t  tail;
      words_in++;
      before_n = event_q.size();
      i = w.index;
      v = $signed(w.value);
      case (w.action)
        ACT_BUTTON: begin
          if (i < button_count && i < BUTTON_SLOTS) begin
            on = (v != 0);
            if (held[i] != on) begin
              held[i] = on;
              // state moves even when unmapped; only mapped buttons emit
              if (button_id_map[i] != '0) add(button_id_map[i], on);
            end
          end
        end
        ACT_AXIS: begin
          if (i < axis_count && i < AXIS_SLOTS) begin
            t = threshold;
            p = axis_last[i];
            if (v <= -t && p > -t) begin
              add(axis_neg_id[i], 1'b1);
              if (p >= t) add(axis_pos_id[i], 1'b0);
            end else if (v >= t && p < t) begin
              if (p <= -t) add(axis_neg_id[i], 1'b0);
              add(axis_pos_id[i], 1'b1);
            end else if (v > -t && v < t) begin
              if (p <= -t) add(axis_neg_id[i], 1'b0);
              else if (p >= t) add(axis_pos_id[i], 1'b0);
            end
            axis_last[i] = w.value;
          end
        end
        ACT_HAT: begin
          if (i < hat_count && i < HAT_SLOTS) begin
            nb = w.value[3:0];
            ob = hat_last[i];
            nx = hat_way(nb, HAT_LEFT, HAT_RIGHT);
            ox = hat_way(ob, HAT_LEFT, HAT_RIGHT);
            ny = hat_way(nb, HAT_UP, HAT_DOWN);
            oy = hat_way(ob, HAT_UP, HAT_DOWN);
            // X first, then Y; release of the old side before press of the new
            if (nx != ox) begin
              if (ox == DIR_NEG) add(hat_left, 1'b0);
              else if (ox == DIR_POS) add(hat_right, 1'b0);
              if (nx == DIR_NEG) add(hat_left, 1'b1);
              else if (nx == DIR_POS) add(hat_right, 1'b1);
            end
            if (ny != oy) begin
              if (oy == DIR_NEG) add(hat_up, 1'b0);
              else if (oy == DIR_POS) add(hat_down, 1'b0);
              if (ny == DIR_NEG) add(hat_up, 1'b1);
              else if (ny == DIR_POS) add(hat_down, 1'b1);
            end
            hat_last[i] = nb;
          end
        end
        ACT_LOAD_BUTTON: begin
          if (i < button_count && i < BUTTON_SLOTS) button_id_map[i] = w.map_low;
        end
        ACT_LOAD_AXIS: begin
          if (i < axis_count && i < AXIS_SLOTS) begin
            axis_neg_id[i] = w.map_low;
            axis_pos_id[i] = w.map_high;
          end
        end
        default: ;
      endcase
      if (event_q.size() > before_n) begin
        tail = event_q.pop_back();
        tail.last = 1'b1;
        event_q.push_back(tail);
      end
    endfunction

    function void check_word(jet_out_t got);
      jet_out_t exp;
      words_out++;
      if (event_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, got id=%h pressed=%b last=%b",
                 $time, got.button_id, got.pressed, got.last);
        errors++;
        return;
      end
      exp = event_q.pop_front();
      if (got.button_id !== exp.button_id) begin
        $display("%0t: button_id mismatch: expected %h, got %h",
                 $time, exp.button_id, got.button_id);
        errors++;
      end
      if (got.pressed !== exp.pressed) begin
        $display("%0t: pressed mismatch on id %h: expected %b, got %b",
                 $time, exp.button_id, exp.pressed, got.pressed);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last mismatch on id %h: expected %b, got %b",
                 $time, exp.button_id, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  jet_event_scoreboard sb = new();

  // Knobs shared between the sender and the receiver.
  int stall_pct     = 0;   // share of receiver runs that stall
  bit gaps_on       = 1'b1;
  bit hold_request  = 1'b0; // receiver picks it up and counts its own hold-off
  int burst_left    = 0;
  int settings_seen = 0;

  // Receiver: checks each accepted word, then picks the next stall value.
  // Stall comes in runs of random length; a hold-off request wins.
  initial begin
    int run_left;
    int hold_left;
    bit run_stall;
    run_left    = 0;
    hold_left   = 0;
    run_stall   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_word_o);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 10);
          run_stall = ($urandom_range(0, 99) < stall_pct);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    end
  end

  function automatic jet_in_t mk(logic [2:0] act, logic [7:0] idx, logic [15:0] val,
                                 logic [15:0] lo, logic [15:0] hi);
    jet_in_t w;
    w.action   = act;
    w.index    = idx;
    w.value    = val;
    w.map_low  = lo;
    w.map_high = hi;
    return w;
  endfunction

  // Offers one word and holds it until accepted; then either goes straight on
  // (inside a burst) or drops valid for a random gap.
  task automatic offer(input jet_in_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  // Sender stops until every predicted word is out, then lets the pipe settle
  // since words that cause no event give nothing to wait on.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all eight registers back to back; only called while idle.
  task automatic program_regs(input logic [15:0] buttons, input logic [15:0] axes,
                              input logic [15:0] hats, input logic [15:0] thr,
                              input logic [15:0] left, input logic [15:0] right,
                              input logic [15:0] up, input logic [15:0] down);
    logic [15:0] vals [8];
    vals[REG_BUTTON_COUNT]   = buttons;
    vals[REG_AXIS_COUNT]     = axes;
    vals[REG_HAT_COUNT]      = hats;
    vals[REG_AXIS_THRESHOLD] = thr;
    vals[REG_HAT_LEFT_ID]    = left;
    vals[REG_HAT_RIGHT_ID]   = right;
    vals[REG_HAT_UP_ID]      = up;
    vals[REG_HAT_DOWN_ID]    = down;
    for (int k = 0; k < 8; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= jet_reg_e'(k);
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      sb.write_reg(jet_reg_e'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  // Random words. Most hit the first few mapped indexes so that loads and
  // uses meet; the rest spread over the whole range, out-of-range included.
  // hold_at / pause_at place the receiver hold-off and a full sender pause.
  task automatic run_random(input int count, input int hold_at, input int pause_at);
    jet_in_t w;
    int      pick, lim, sel, t, av;
    for (int n = 0; n < count; n++) begin
      w.index    = 8'($urandom);
      w.value    = 16'($urandom);
      w.map_low  = 16'($urandom);
      w.map_high = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        w.action = ACT_BUTTON;
        lim = (sb.button_count < BUTTON_SLOTS) ? sb.button_count : BUTTON_SLOTS;
      end else if (pick < 55) begin
        w.action = ACT_AXIS;
        lim = (sb.axis_count < AXIS_SLOTS) ? sb.axis_count : AXIS_SLOTS;
      end else if (pick < 75) begin
        w.action = ACT_HAT;
        lim = (sb.hat_count < HAT_SLOTS) ? sb.hat_count : HAT_SLOTS;
      end else if (pick < 85) begin
        w.action = ACT_LOAD_BUTTON;
        lim = (sb.button_count < BUTTON_SLOTS) ? sb.button_count : BUTTON_SLOTS;
      end else if (pick < 95) begin
        w.action = ACT_LOAD_AXIS;
        lim = (sb.axis_count < AXIS_SLOTS) ? sb.axis_count : AXIS_SLOTS;
      end else begin
        w.action = 3'($urandom_range(ACT_RSVD_A, ACT_RSVD_C));
        lim = 0;
      end
      sel = $urandom_range(0, 99);
      if (lim > 0 && sel < 80) w.index = 8'($urandom_range(0, ((lim < 16) ? lim : 16) - 1));
      else if (lim > 0 && sel < 90) w.index = 8'($urandom_range(0, lim - 1));
      if (w.action == ACT_BUTTON && $urandom_range(0, 1) == 0) w.value = '0;
      if (w.action == ACT_LOAD_BUTTON && $urandom_range(0, 9) == 0) w.map_low = '0;
      if (w.action == ACT_AXIS) begin
        // positions at and around the thresholds and the rails
        t = sb.threshold;
        case ($urandom_range(0, 7))
          0: av = -32768;
          1: av = 32767;
          2: av = t;
          3: av = -t;
          4: av = t - 1;
          5: av = 1 - t;
          6: av = 0;
          default: av = $signed(w.value);
        endcase
        w.value = 16'(av);
      end
      if (n == hold_at) begin
        hold_request = 1'b1;
        gaps_on      = 1'b0;
      end
      if (hold_at >= 0 && n == hold_at + 30) gaps_on = 1'b1;
      if (n == pause_at) drain();
      offer(w);
    end
  endtask

  // Hard stop in case the block hangs or loses words.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d words still expected", $time, sb.pending());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_BUTTON_COUNT;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All counts zero: every word, loads included, must be ignored.
    stall_pct = 20;
    program_regs(16'd0, 16'd0, 16'd0, 16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(mk(ACT_BUTTON,      8'd0, 16'h0001, 16'h0000, 16'h0000));
    offer(mk(ACT_AXIS,        8'd0, 16'h8000, 16'h0000, 16'h0000));
    offer(mk(ACT_HAT,         8'd0, 16'h0001, 16'h0000, 16'h0000));
    offer(mk(ACT_LOAD_BUTTON, 8'd3, 16'h0000, 16'h0777, 16'h0000));
    offer(mk(ACT_LOAD_AXIS,   8'd0, 16'h0000, 16'h1111, 16'h2222));
    drain();

    // Directed: full counts, default threshold, distinct hat ids.
    program_regs(16'd256, 16'd256, 16'd16, 16'd16384, 16'h00A1, 16'h00A2, 16'h00A3, 16'h00A4);
    offer(mk(ACT_LOAD_BUTTON, 8'd0,   16'h0000, 16'h1234, 16'h0000));
    offer(mk(ACT_LOAD_BUTTON, 8'd255, 16'h0000, 16'hFFFF, 16'h0000));
    offer(mk(ACT_BUTTON, 8'd0,   16'h0001, 16'h0000, 16'h0000));  // press
    offer(mk(ACT_BUTTON, 8'd0,   16'h8000, 16'h0000, 16'h0000));  // still held: silent
    offer(mk(ACT_BUTTON, 8'd0,   16'h0000, 16'h0000, 16'h0000));  // release
    offer(mk(ACT_BUTTON, 8'd3,   16'h7FFF, 16'h0000, 16'h0000));  // map load was ignored
    offer(mk(ACT_BUTTON, 8'd255, 16'hFFFF, 16'h0000, 16'h0000));
    offer(mk(ACT_LOAD_AXIS, 8'd0, 16'h0000, 16'h0001, 16'h8000));
    offer(mk(ACT_AXIS, 8'd0,   16'h8000, 16'h0000, 16'h0000));    // low end
    offer(mk(ACT_AXIS, 8'd0,   16'h7FFF, 16'h0000, 16'h0000));    // low to high
    offer(mk(ACT_AXIS, 8'd0,   16'h0000, 16'h0000, 16'h0000));    // back to center
    offer(mk(ACT_AXIS, 8'd0,   16'h4000, 16'h0000, 16'h0000));    // exactly +threshold
    offer(mk(ACT_AXIS, 8'd0,   16'hC000, 16'h0000, 16'h0000));    // exactly -threshold
    offer(mk(ACT_AXIS, 8'd0,   16'hC001, 16'h0000, 16'h0000));    // just inside
    offer(mk(ACT_AXIS, 8'd255, 16'h5000, 16'h0000, 16'h0000));    // unmapped end, id 0
    offer(mk(ACT_HAT, 8'd0,  16'h0003, 16'h0000, 16'h0000));      // up + right
    offer(mk(ACT_HAT, 8'd0,  16'h000C, 16'h0000, 16'h0000));      // flip both: four words
    offer(mk(ACT_HAT, 8'd0,  16'h000F, 16'h0000, 16'h0000));      // all opposing: centered
    offer(mk(ACT_HAT, 8'd15, 16'hFFF5, 16'h0000, 16'h0000));      // up+down, junk upper bits
    offer(mk(ACT_HAT, 8'd15, 16'h8008, 16'h0000, 16'h0000));
    offer(mk(ACT_HAT, 8'd16, 16'h0001, 16'h0000, 16'h0000));      // beyond last hat
    offer(mk(ACT_RSVD_A,        8'd0, 16'h0001, 16'hFFFF, 16'hFFFF));
    offer(mk(ACT_RSVD_A + 3'd1, 8'd0, 16'h0001, 16'hFFFF, 16'hFFFF));
    offer(mk(ACT_RSVD_C,        8'd0, 16'h0001, 16'hFFFF, 16'hFFFF));
    drain();

    // Random, full counts, random threshold; long hold-off, then a full pause.
    stall_pct = 30;
    program_regs(16'd256, 16'd256, 16'd16, 16'($urandom_range(1, 32767)),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(100, 40, 75);
    drain();

    // Few inputs present, smallest nonzero threshold, hat ids at the rails.
    stall_pct = 60;
    program_regs(16'd4, 16'd3, 16'd2, 16'd1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    run_random(70, -1, -1);
    drain();

    // Counts past the array sizes, largest threshold, no idling on either side.
    stall_pct = 0;
    gaps_on   = 1'b0;
    program_regs(16'd511, 16'd511, 16'd31, 16'd32767,
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(70, -1, -1);
    drain();

    // Zero threshold: both axis ends sit at the center.
    stall_pct = 30;
    gaps_on   = 1'b1;
    program_regs(16'd1, 16'd16, 16'd16, 16'd0,
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(60, -1, -1);
    drain();

    $display("Covered %0d gamepad words and %0d event words over %0d register settings,",
             sb.words_in, sb.words_out, settings_seen);
    $display("with receiver hold-off, sender pauses and bursts; %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/jet_pkg.sv
hw/rtl/jet_ram.sv
hw/rtl/jet_fifo.sv
hw/rtl/jet_front.sv
hw/rtl/jet_back.sv
hw/rtl/joystick_event_translator.sv
tb/sv/joystick_event_translator_test.sv
